// ----- design/svt_pkg.sv -----
// Package for the sorted vector table: item kinds and the structs passed
// between the top level and the cell chain. No dependencies.
package svt_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH     = 3'd0,
    KIND_ERASE    = 3'd1,
    KIND_ERASE_AT = 3'd2,
    KIND_READ_AT  = 3'd3,
    KIND_INDEX_OF = 3'd4,
    KIND_CLEAR    = 3'd5
  } svt_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_FULL      = 2'd2
  } svt_status_e;

  // Operation broadcast to every cell, already qualified by the top level.
  typedef struct packed {
    logic push;       // push with room left
    logic erase_val;  // erase first equal key
    logic erase_at;   // erase at a checked position
    logic desc;       // descending order
  } svt_op_t;

  // Flags handed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic valid;  // this cell holds an entry
    logic mv;     // this cell moves its entry one place up on push
    logic hit;    // an equal key sits in this cell or to its left
  } svt_link_t;

endpackage

// ----- design/svt_if.sv -----
// Channel interfaces of the sorted vector table: request, response and
// configuration write. No dependencies.
interface svt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [4:0]  index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

interface svt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [4:0]  position;
  logic        found;
  logic [4:0]  count;
  logic [1:0]  status;

  modport source (output valid, read_value, position, found, count, status, input ready);
  modport sink   (input valid, read_value, position, found, count, status, output ready);
endinterface

interface svt_cfg_if;
  logic valid;
  logic ready;
  logic descending;

  modport source (output valid, descending, input ready);
  modport sink   (input valid, descending, output ready);
endinterface

// ----- design/svt_cell.sv -----
// One cell of the sorted vector chain: holds one entry, compares it with the
// broadcast key and shifts with its neighbors. Depends on svt_pkg.
module svt_cell import svt_pkg::*; #(
  parameter int KEY_WIDTH = 32,
  parameter int CW        = 5,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  svt_op_t              op_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [CW-1:0]        count_i,
  input  logic [CW-1:0]        sel_i,
  input  svt_link_t            link_i,
  output svt_link_t            link_o,
  input  logic                 tail_i,
  output logic                 tail_o,
  input  logic [KEY_WIDTH-1:0] left_val_i,
  input  logic [KEY_WIDTH-1:0] right_val_i,
  output logic [KEY_WIDTH-1:0] value_o,
  input  logic [CW-1:0]        pos_i,
  output logic [CW-1:0]        pos_o,
  input  logic [KEY_WIDTH-1:0] rd_i,
  output logic [KEY_WIDTH-1:0] rd_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX + 1);

  logic [KEY_WIDTH-1:0] entry_q, entry_d;
  logic valid, at_end, gt, mv, match, rm;

  always_comb begin
    valid  = MY_IDX < count_i;
    at_end = link_i.valid & ~valid;
    // entry must sit after the key in the configured order
    if (op_i.desc) begin
      gt = valid & ($signed(entry_q) < $signed(key_i));
    end else begin
      gt = valid & ($signed(entry_q) > $signed(key_i));
    end
    mv     = gt & tail_i;
    tail_o = ~valid | mv;
    match  = valid & (entry_q == key_i);
    rm     = valid & ((op_i.erase_val & (link_i.hit | match)) |
                      (op_i.erase_at & (MY_IDX >= sel_i)));

    link_o.valid = valid;
    link_o.mv    = mv;
    link_o.hit   = link_i.hit | match;

    pos_o = (match & ~link_i.hit) ? MY_POS : pos_i;
    rd_o  = (MY_IDX == sel_i) ? entry_q : rd_i;

    entry_d = entry_q;
    if (op_i.push) begin
      if (link_i.mv) begin
        entry_d = left_val_i;
      end else if (mv | at_end) begin
        entry_d = key_i;
      end
    end else if (rm) begin
      entry_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign value_o = entry_q;

endmodule

// ----- design/sorted_vector_table.sv -----
// Sorted vector table top level: request decode, fill count, order register,
// response register and the chain of svt_cell. Depends on svt_pkg, svt_if.
//
//  channel  | direction | payload                                   | handshake
//  ---------+-----------+-------------------------------------------+-------------
//  req_i    | in        | kind, value, index                        | valid/ready
//  rsp_o    | out       | read_value, position, found, count, status| valid/ready
//  cfg_i    | in        | descending                                | valid/ready
//
// The cells compare the key in parallel and the move, match, position and read
// flags ripple along the chain, so the whole row of entries updates at the
// accepting edge.
// One response register sits on the output; a new request is taken whenever
// that register is empty or being drained, so a stalled response only holds
// off the request side. Reset empties the vector and selects ascending order;
// entries keep no reset and are never read above the fill count.
module sorted_vector_table import svt_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  svt_req_if.sink   req_i,
  svt_rsp_if.source rsp_o,
  svt_cfg_if.sink   cfg_i
);

  localparam int CW = $clog2(DEPTH + 1);    // fill count width
  localparam int IW = (CW > 5) ? CW : 5;    // width for index checks

  logic          descending_q;
  logic [CW-1:0] count_q, count_d;

  logic req_fire;
  assign req_fire    = req_i.valid & req_i.ready;
  assign req_i.ready = ~rsp_o.valid | rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  // --- key extract: low KEY_WIDTH bits of the request value, zero-extended above 32 bits
  logic [KEY_WIDTH-1:0] key;
  generate
    if (KEY_WIDTH <= 32) begin : g_key_narrow
      assign key = req_i.value[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign key = {{(KEY_WIDTH-32){1'b0}}, req_i.value};
    end
  endgenerate

  // --- index range check (1-based)
  logic [IW-1:0] idx_ext, cnt_ext;
  logic          bad_idx, full;
  logic [CW-1:0] sel;
  assign idx_ext = IW'(req_i.index);
  assign cnt_ext = IW'(count_q);
  assign bad_idx = (idx_ext == '0) || (idx_ext > cnt_ext);
  assign sel     = CW'(idx_ext - IW'(1));
  assign full    = count_q >= CW'(DEPTH);

  svt_kind_e kind;
  assign kind = svt_kind_e'(req_i.kind);

  svt_op_t op;
  always_comb begin
    op.push      = req_fire & (kind == KIND_PUSH) & ~full;
    op.erase_val = req_fire & (kind == KIND_ERASE);
    op.erase_at  = req_fire & (kind == KIND_ERASE_AT) & ~bad_idx;
    op.desc      = descending_q;
  end

  // --- cell chain; link, position and read data ripple left to right,
  //     the push tail flag ripples right to left
  svt_link_t            link_w [DEPTH+1];
  logic                 tail_w [DEPTH+1];
  logic [CW-1:0]        pos_w  [DEPTH+1];
  logic [KEY_WIDTH-1:0] rd_w   [DEPTH+1];
  logic [KEY_WIDTH-1:0] val_w  [DEPTH];

  assign link_w[0]     = '{valid: 1'b1, mv: 1'b0, hit: 1'b0};
  assign pos_w[0]      = '0;
  assign rd_w[0]       = '0;
  assign tail_w[DEPTH] = 1'b1;

  generate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      svt_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CW        (CW),
        .IDX       (g)
      ) u_cell (
        .clk_i       (clk_i),
        .op_i        (op),
        .key_i       (key),
        .count_i     (count_q),
        .sel_i       (sel),
        .link_i      (link_w[g]),
        .link_o      (link_w[g+1]),
        .tail_i      (tail_w[g+1]),
        .tail_o      (tail_w[g]),
        .left_val_i  (val_w[(g == 0) ? 0 : g-1]),
        .right_val_i (val_w[(g == DEPTH-1) ? g : g+1]),
        .value_o     (val_w[g]),
        .pos_i       (pos_w[g]),
        .pos_o       (pos_w[g+1]),
        .rd_i        (rd_w[g]),
        .rd_o        (rd_w[g+1])
      );
    end
  endgenerate

  // tail_w[0] is the "all entries move" flag; nothing reads it
  logic hit_any;
  assign hit_any = link_w[DEPTH].hit;

  // --- read data sign extension (truncation for wide keys) to the 32-bit response field
  logic [31:0] rd32;
  generate
    if (KEY_WIDTH >= 32) begin : g_rd_wide
      assign rd32 = rd_w[DEPTH][31:0];
    end else begin : g_rd_narrow
      assign rd32 = {{(32-KEY_WIDTH){rd_w[DEPTH][KEY_WIDTH-1]}}, rd_w[DEPTH]};
    end
  endgenerate

  // --- next count and response payload
  logic [31:0] read_value_d;
  logic [CW-1:0] position_d;
  logic found_d;
  svt_status_e status_d;

  always_comb begin
    count_d      = count_q;
    read_value_d = '0;
    position_d   = '0;
    found_d      = 1'b0;
    status_d     = STATUS_OK;
    case (kind)
      KIND_PUSH: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      KIND_ERASE: begin
        found_d = hit_any;
        if (hit_any) begin
          count_d = count_q - CW'(1);
        end
      end
      KIND_ERASE_AT: begin
        if (bad_idx) begin
          status_d = STATUS_BAD_INDEX;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      KIND_READ_AT: begin
        if (bad_idx) begin
          status_d = STATUS_BAD_INDEX;
        end else begin
          read_value_d = rd32;
        end
      end
      KIND_INDEX_OF: begin
        position_d = pos_w[DEPTH];
        found_d    = hit_any;
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // --- control state
  logic rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      descending_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (req_fire) begin
        count_q <= count_d;
      end
      if (cfg_i.valid) begin
        descending_q <= cfg_i.descending;
      end
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // --- response payload register
  logic [31:0] read_value_q;
  logic [4:0]  position_q, count_out_q;
  logic        found_q;
  logic [1:0]  status_q;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      read_value_q <= read_value_d;
      position_q   <= 5'(position_d);
      found_q      <= found_d;
      count_out_q  <= 5'(count_d);
      status_q     <= status_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = read_value_q;
  assign rsp_o.position   = position_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.count      = count_out_q;
  assign rsp_o.status     = status_q;

  // --- assertions
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_rsp_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_o.valid)
    else $error("accepted request gave no response");

  a_rsp_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.count == 5'(count_q)))
    else $error("response count differs from fill count");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && kind == KIND_PUSH && full) |=> (count_q == $past(count_q)))
    else $error("push into full vector changed the count");

  a_pos_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.position != 5'd0) |-> rsp_o.found)
    else $error("position given without found");

endmodule
